[sv/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Shared constants, item type and helper functions of the bit vector engine.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int MAX_BITS     = 4096;
   localparam int CHUNK_BITS   = 64;
   localparam int STORE_CHUNKS = 64;

   localparam logic [3:0] CMD_GETBIT    = 4'd0;
   localparam logic [3:0] CMD_SETBIT    = 4'd1;
   localparam logic [3:0] CMD_READCHUNK = 4'd2;
   localparam logic [3:0] CMD_WRITECHUNK= 4'd3;
   localparam logic [3:0] CMD_CLEAR     = 4'd4;
   localparam logic [3:0] CMD_FILL      = 4'd5;
   localparam logic [3:0] CMD_AND       = 4'd6;
   localparam logic [3:0] CMD_OR        = 4'd7;
   localparam logic [3:0] CMD_ANDNOT    = 4'd8;
   localparam logic [3:0] CMD_POPCOUNT  = 4'd9;
   localparam logic [3:0] CMD_EMPTY     = 4'd10;
   localparam logic [3:0] CMD_LIST      = 4'd11;
   localparam logic [3:0] CMD_SETWIDTH  = 4'd12;
   localparam logic [3:0] CMD_GROW      = 4'd13;
   localparam logic [3:0] CMD_COMPARE   = 4'd14;

   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_BIT   = 3'd1;
   localparam logic [2:0] CLS_CHUNK = 3'd2;
   localparam logic [2:0] CLS_WHOLE = 3'd3;
   localparam logic [2:0] CLS_SIZE  = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_NONE  = 2'd2;

   typedef struct packed {
      logic [3:0]  command;
      logic [2:0]  op_class;
      logic [11:0] bit_index;
      logic        bit_value;
      logic [5:0]  chunk_index;
      logic [63:0] chunk_data;
      logic [12:0] width_amount;
   } item_type;

   // Bits of chunk idx that lie below width w.
   function automatic logic [63:0] width_mask(input logic [12:0] w, input logic [5:0] idx);
      logic [12:0] lo;
      logic [12:0] rem;
      lo = {1'b0, idx, 6'b0};
      rem = w - lo;
      if (w <= lo) begin
         return 64'd0;
      end else if (rem >= 13'd64) begin
         return {64{1'b1}};
      end else begin
         return (64'd1 << rem[5:0]) - 64'd1;
      end
   endfunction

   function automatic logic [6:0] popcount64(input logic [63:0] v);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 64; i++) begin
         n = n + {6'd0, v[i]};
      end
      return n;
   endfunction

   function automatic logic [5:0] lowest_set(input logic [63:0] v);
      logic [5:0] idx;
      idx = 6'd0;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            idx = 6'(i);
         end
      end
      return idx;
   endfunction

endpackage

[sv/bse_ram.sv]
// ----------------------------------------------------------------------------
// bse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/bse_front.sv]
// ----------------------------------------------------------------------------
// bse_front
// Accepts command items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bse_front
   import bse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [11:0] req_bit_index,
   input  logic        req_bit_value,
   input  logic [5:0]  req_chunk_index,
   input  logic [63:0] req_chunk_data,
   input  logic [12:0] req_width_amount,
   output logic        q_valid,
   output item_type    q_head,
   input  logic        q_pop
);

   item_type    q_ff [2];
   logic        wp_ff, wp_in;
   logic        rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   item_type    item_c;
   logic [2:0]  cls_c;

   always_comb begin
      unique case (req_command)
         CMD_GETBIT, CMD_SETBIT: cls_c = CLS_BIT;
         CMD_READCHUNK, CMD_WRITECHUNK, CMD_AND, CMD_OR, CMD_ANDNOT,
         CMD_COMPARE, CMD_LIST: cls_c = CLS_CHUNK;
         CMD_CLEAR, CMD_FILL, CMD_POPCOUNT, CMD_EMPTY: cls_c = CLS_WHOLE;
         CMD_SETWIDTH, CMD_GROW: cls_c = CLS_SIZE;
         default: cls_c = CLS_NONE;
      endcase
   end

   assign item_c = '{command: req_command, op_class: cls_c, bit_index: req_bit_index,
                     bit_value: req_bit_value, chunk_index: req_chunk_index,
                     chunk_data: req_chunk_data, width_amount: req_width_amount};

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_head  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = q_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= item_c;
      end
   end

endmodule

[sv/bse_back.sv]
// ----------------------------------------------------------------------------
// bse_back
// Executes queued items against the chunk store and produces the results.
// ----------------------------------------------------------------------------
module bse_back
   import bse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_value,
   output logic [12:0] rsp_number,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_LIST  = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_COUNT = 3'd4;
   localparam logic [2:0] S_TRIM  = 3'd5;

   logic [2:0]  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [12:0] width_ff, width_in;
   logic [63:0] valid_ff, valid_in;
   logic        valid_rd_ff, valid_rd_in;
   logic [5:0]  walk_ff, walk_in;
   logic [12:0] count_ff, count_in;
   logic [63:0] list_ff, list_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic [12:0] rsp_number_ff, rsp_number_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [63:0] wr_data;
   logic [5:0]  rd_addr;
   logic [63:0] rd_data;
   logic [63:0] chunk_d;
   logic [63:0] new_v;
   logic [5:0]  chunk_a;
   logic [13:0] size_n;
   logic [12:0] sum_c;
   logic [5:0]  low_c;
   logic [63:0] rest_c;
   logic [63:0] keep_c;

   bse_ram #(.WIDTH(64), .DEPTH(STORE_CHUNKS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // A chunk never written since it was last cleared reads as zero.
   assign chunk_d = valid_rd_ff ? rd_data : 64'd0;
   assign chunk_a = (item_ff.op_class == CLS_BIT) ? item_ff.bit_index[11:6]
                                                  : item_ff.chunk_index;
   assign q_pop   = (state_ff == S_IDLE) && q_valid;
   assign sum_c   = count_ff + {6'd0, popcount64(chunk_d)};
   assign low_c   = lowest_set(list_ff);
   assign rest_c  = list_ff & ~(64'd1 << low_c);
   assign size_n  = (q_head.command == CMD_SETWIDTH) ? {1'b0, q_head.width_amount}
                    : {1'b0, width_ff} + {1'b0, q_head.width_amount};

   always_comb begin
      for (int i = 0; i < 64; i++) begin
         keep_c[i] = ({1'b0, 6'(i), 6'd0} < size_n[12:0]);
      end
   end

   always_comb begin
      unique case (item_ff.command)
         CMD_WRITECHUNK: new_v = item_ff.chunk_data;
         CMD_AND:        new_v = chunk_d & item_ff.chunk_data;
         CMD_OR:         new_v = chunk_d | item_ff.chunk_data;
         default:        new_v = chunk_d & ~item_ff.chunk_data;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      width_in      = width_ff;
      valid_in      = valid_ff;
      walk_in       = walk_ff;
      count_in      = count_ff;
      list_in       = list_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = 64'd0;
      rsp_number_in = 13'd0;
      rsp_last_in   = 1'b1;
      rsp_status_in = STAT_OK;
      wr_en         = 1'b0;
      wr_addr       = walk_ff;
      wr_data       = 64'd0;
      rd_addr       = 6'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in = q_head;
               unique case (q_head.op_class)
                  CLS_BIT: begin
                     if ({1'b0, q_head.bit_index} >= width_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rd_addr  = q_head.bit_index[11:6];
                        state_in = S_EXEC;
                     end
                  end
                  CLS_CHUNK: begin
                     if ({1'b0, q_head.chunk_index, 6'd0} >= width_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rd_addr  = q_head.chunk_index;
                        state_in = S_EXEC;
                     end
                  end
                  CLS_WHOLE: begin
                     if (q_head.command == CMD_CLEAR ||
                         (q_head.command == CMD_FILL && !q_head.bit_value)) begin
                        valid_in     = 64'd0;
                        rsp_valid_in = 1'b1;
                     end else if (q_head.command == CMD_FILL) begin
                        walk_in  = 6'd0;
                        state_in = S_FILL;
                     end else begin
                        rd_addr  = 6'd0;
                        walk_in  = 6'd0;
                        count_in = 13'd0;
                        state_in = S_COUNT;
                     end
                  end
                  CLS_SIZE: begin
                     if (size_n > 14'(MAX_BITS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_number_in = width_ff;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        width_in = size_n[12:0];
                        valid_in = valid_ff & keep_c;
                        // Only the chunk that the new width cuts through needs a rewrite.
                        if (size_n[5:0] != 6'd0 && valid_ff[size_n[11:6]]) begin
                           rd_addr  = size_n[11:6];
                           walk_in  = size_n[11:6];
                           state_in = S_TRIM;
                        end else begin
                           rsp_valid_in  = 1'b1;
                           rsp_number_in = size_n[12:0];
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            priority if (item_ff.command == CMD_GETBIT) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = {63'd0, chunk_d[item_ff.bit_index[5:0]]};
            end else if (item_ff.command == CMD_SETBIT) begin
               wr_en              = 1'b1;
               wr_addr            = chunk_a;
               wr_data            = chunk_d;
               wr_data[item_ff.bit_index[5:0]] = item_ff.bit_value;
               valid_in[chunk_a]  = 1'b1;
               rsp_valid_in       = 1'b1;
            end else if (item_ff.command == CMD_READCHUNK) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = chunk_d;
            end else if (item_ff.command == CMD_COMPARE) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = {63'd0, chunk_d == item_ff.chunk_data};
            end else if (item_ff.command == CMD_LIST) begin
               if (chunk_d == 64'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NONE;
               end else begin
                  list_in  = chunk_d;
                  state_in = S_LIST;
               end
            end else begin
               wr_en             = 1'b1;
               wr_addr           = chunk_a;
               wr_data           = new_v & width_mask(width_ff, chunk_a);
               valid_in[chunk_a] = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_value_in      = wr_data;
            end
         end
         S_LIST: begin
            list_in       = rest_c;
            rsp_valid_in  = 1'b1;
            rsp_number_in = {1'b0, item_ff.chunk_index, low_c};
            rsp_last_in   = (rest_c == 64'd0);
            if (rest_c == 64'd0) begin
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            wr_en             = 1'b1;
            wr_data           = width_mask(width_ff, walk_ff);
            valid_in[walk_ff] = 1'b1;
            walk_in           = walk_ff + 6'd1;
            if (walk_ff == 6'(STORE_CHUNKS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_COUNT: begin
            count_in = sum_c;
            if (walk_ff == 6'(STORE_CHUNKS - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (item_ff.command == CMD_POPCOUNT) begin
                  rsp_number_in = sum_c;
               end else begin
                  rsp_value_in = {63'd0, sum_c == 13'd0};
               end
            end else begin
               rd_addr = walk_ff + 6'd1;
               walk_in = walk_ff + 6'd1;
            end
         end
         S_TRIM: begin
            wr_en         = 1'b1;
            wr_data       = chunk_d & width_mask(width_ff, walk_ff);
            rsp_valid_in  = 1'b1;
            rsp_number_in = width_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      valid_rd_in = valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= 13'd0;
         valid_ff     <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      valid_rd_ff   <= valid_rd_in;
      walk_ff       <= walk_in;
      count_ff      <= count_in;
      list_ff       <= list_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_number_ff <= rsp_number_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_number     = rsp_number_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

   a_list_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST |-> list_ff != 64'd0)
      else $error("list walk entered with no bits left");

   a_width_max: assert property (@(posedge clock) disable iff (reset)
      width_ff <= 13'(MAX_BITS))
      else $error("width beyond maximum");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff != 2'd3)
      else $error("undefined status code");

   a_list_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST && rest_c == 64'd0 |=> rsp_valid_ff && rsp_last_ff)
      else $error("final listed bit not marked last");

endmodule

[sv/bitset_store_engine.sv]
// ----------------------------------------------------------------------------
// bitset_store_engine
// Bit vector of up to 4096 bits in 64-bit chunks with bit, chunk and whole
// vector commands.
// ----------------------------------------------------------------------------
// Usage: drive the req_ fields and raise start; the item is taken at a clock
// edge where start is high and busy is low. A two-entry queue sits in front
// of the executing back end, so a new item may be taken while an earlier one
// is still being worked on; busy rises only when the queue is full.
// Each result appears on the rsp_ ports for one cycle with rsp_valid high;
// the receiver cannot hold results off. Every item gives one result, except
// list, which gives one per set bit, the final one with rsp_last set, or one
// with status none or range if it lists no bit. The back end ends each item
// before it takes the next: bit and chunk commands read, then modify and
// answer; out-of-range items, clear, zero fill, resize without a cut chunk
// and unused commands answer at decode; resize cutting a chunk reads, then
// rewrites it; list reads, then gives one result per set bit; fill, popcount
// and empty walk all 64 chunks one per cycle after decode. Each result is
// registered before it reaches the rsp_ ports. Reset empties the queue, sets
// the width to zero and marks every chunk cleared; then items can be taken.
// ----------------------------------------------------------------------------
module bitset_store_engine
   import bse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_command,
   input  logic [11:0] req_bit_index,
   input  logic        req_bit_value,
   input  logic [5:0]  req_chunk_index,
   input  logic [63:0] req_chunk_data,
   input  logic [12:0] req_width_amount,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_value,
   output logic [12:0] rsp_number,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   logic     q_valid;
   logic     q_pop;
   item_type q_head;

   bse_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_bit_index   (req_bit_index),
      .req_bit_value   (req_bit_value),
      .req_chunk_index (req_chunk_index),
      .req_chunk_data  (req_chunk_data),
      .req_width_amount(req_width_amount),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop)
   );

   bse_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_read_value(rsp_read_value),
      .rsp_number    (rsp_number),
      .rsp_last      (rsp_last),
      .rsp_status    (rsp_status)
   );

endmodule
